[rtl/core/spq_pkg.sv]
// Shared types and constants of the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   localparam int DefaultDepth = 16;
   localparam int KeyWidth     = 32;
   localparam int OccWidth     = 5;

   typedef enum logic [0:0] {
      ACT_ENQUEUE = 1'b0,
      ACT_DEQUEUE = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ENQ_READ,
      S_ENQ_CMP,
      S_ENQ_PLACE,
      S_DEQ_READ,
      S_DEQ_TAKE,
      S_FINISH
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic       load;      // capture key, idx <= count, clear taken value
      logic       rd_prev;   // read entry idx-1 (else read head)
      logic       wr_shift;  // move read entry up to slot idx
      logic       wr_key;    // write key into slot idx
      logic       idx_dec;
      logic       deq_take;  // capture head, advance head, decrement count
      logic       cnt_inc;
      logic       out_load;
      status_type out_code;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic full;
      logic empty;
      logic greater;   // read entry is greater than the key
      logic idx_one;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

[rtl/core/sorted_priority_queue_top.sv]
// Top level of the sorted priority queue (min first, stable for equal keys).
//
// Usage: drive req_action (0 enqueue req_key, 1 dequeue smallest) with req_valid.
// A transfer happens on a rising edge with valid high and stall low. Every
// request gives exactly one result on rsp_*: rsp_value (dequeued key or zero),
// rsp_status (0 done, 1 enqueue dropped because full, 2 dequeue on empty) and
// rsp_occupancy (keys stored after the request, low 5 bits).
// An enqueue examines m stored keys, m = min(k + 1, count) with k the stored
// keys greater than the new key. The insertion loop moves one entry at a time
// through the key store: a registered read of the entry, then a compare and a
// write back one slot up.
// One request is in flight at a time; req_stall is low only while idle, so a
// new request is taken only after the last one has put its result into the
// output register.
// The result sits in an output register, so the next request is taken while a
// finished result still waits. A stalled result holds; the block finishes its
// next request and waits for the register to free.
// Reset empties the queue (count and head pointer); the store needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_top #(
   parameter int DEPTH = spq_pkg::DefaultDepth
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_action,
   input  wire logic signed [spq_pkg::KeyWidth-1:0] req_key,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [spq_pkg::KeyWidth-1:0]      rsp_value,
   output logic [1:0]                               rsp_status,
   output logic [spq_pkg::OccWidth-1:0]             rsp_occupancy
);

   spq_pkg::cmd_type cmd;
   spq_pkg::sts_type sts;

   // sequence each request: decide, walk the store, place, hand off result
   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   // key store as a circular buffer: head is the smallest key
   spq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_key       (req_key),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value     (rsp_value),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy)
   );

endmodule

`default_nettype wire

[rtl/core/spq_ctrl.sv]
// Controller state machine of the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_action,
   output logic                 req_stall,
   input  wire spq_pkg::sts_type sts,
   output spq_pkg::cmd_type     cmd
);

   spq_pkg::state_type  state_ff, state_in;
   spq_pkg::status_type code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spq_pkg::S_IDLE;
         code_ff  <= spq_pkg::ST_DONE;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      req_stall    = 1'b1;
      cmd.load     = 1'b0;
      cmd.rd_prev  = 1'b0;
      cmd.wr_shift = 1'b0;
      cmd.wr_key   = 1'b0;
      cmd.idx_dec  = 1'b0;
      cmd.deq_take = 1'b0;
      cmd.cnt_inc  = 1'b0;
      cmd.out_load = 1'b0;
      cmd.out_code = code_ff;
      case (state_ff)
         spq_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               code_in  = spq_pkg::ST_DONE;
               if (req_action == spq_pkg::ACT_ENQUEUE) begin
                  if (sts.full) begin
                     code_in  = spq_pkg::ST_FULL;
                     state_in = spq_pkg::S_FINISH;
                  end else if (sts.empty) begin
                     state_in = spq_pkg::S_ENQ_PLACE;
                  end else begin
                     state_in = spq_pkg::S_ENQ_READ;
                  end
               end else begin
                  if (sts.empty) begin
                     code_in  = spq_pkg::ST_EMPTY;
                     state_in = spq_pkg::S_FINISH;
                  end else begin
                     state_in = spq_pkg::S_DEQ_READ;
                  end
               end
            end
         end
         spq_pkg::S_ENQ_READ: begin
            cmd.rd_prev = 1'b1;
            state_in    = spq_pkg::S_ENQ_CMP;
         end
         spq_pkg::S_ENQ_CMP: begin
            if (sts.greater) begin
               cmd.wr_shift = 1'b1;
               cmd.idx_dec  = 1'b1;
               state_in     = sts.idx_one ? spq_pkg::S_ENQ_PLACE : spq_pkg::S_ENQ_READ;
            end else begin
               state_in = spq_pkg::S_ENQ_PLACE;
            end
         end
         spq_pkg::S_ENQ_PLACE: begin
            cmd.wr_key  = 1'b1;
            cmd.cnt_inc = 1'b1;
            state_in    = spq_pkg::S_FINISH;
         end
         spq_pkg::S_DEQ_READ: begin
            state_in = spq_pkg::S_DEQ_TAKE;
         end
         spq_pkg::S_DEQ_TAKE: begin
            cmd.deq_take = 1'b1;
            state_in     = spq_pkg::S_FINISH;
         end
         spq_pkg::S_FINISH: begin
            // hold until the result register can take the transfer
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = spq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = spq_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/core/spq_dpath.sv]
// Datapath of the sorted priority queue: key store, pointers and result register.
`timescale 1ns / 1ps
`default_nettype none

module spq_dpath #(
   parameter int DEPTH = spq_pkg::DefaultDepth
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic signed [spq_pkg::KeyWidth-1:0] req_key,
   input  wire spq_pkg::cmd_type                   cmd,
   output spq_pkg::sts_type                        sts,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [spq_pkg::KeyWidth-1:0]      rsp_value,
   output logic [1:0]                              rsp_status,
   output logic [spq_pkg::OccWidth-1:0]            rsp_occupancy
);

   localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam int SumW = IdxW + 1;

   logic signed [spq_pkg::KeyWidth-1:0] mem [DEPTH];
   logic signed [spq_pkg::KeyWidth-1:0] rdata_ff;
   logic signed [spq_pkg::KeyWidth-1:0] key_ff;
   logic signed [spq_pkg::KeyWidth-1:0] take_ff;
   logic [IdxW-1:0]                     head_ff;
   logic [IdxW-1:0]                     idx_ff;
   logic [CntW-1:0]                     count_ff;

   logic signed [spq_pkg::KeyWidth-1:0] value_ff;
   logic [1:0]                          status_ff;
   logic [spq_pkg::OccWidth-1:0]        occ_ff;
   logic                                valid_ff, valid_in;

   logic [IdxW-1:0] idx_prev;
   logic [SumW-1:0] sum_cur, sum_prev;
   logic [IdxW-1:0] phys_cur, phys_prev, rd_addr, head_next;
   logic            wr_en;
   logic signed [spq_pkg::KeyWidth-1:0] wr_data;

   // logical slot -> physical address in the circular store
   assign idx_prev  = idx_ff - IdxW'(1);
   assign sum_cur   = {1'b0, head_ff} + {1'b0, idx_ff};
   assign sum_prev  = {1'b0, head_ff} + {1'b0, idx_prev};
   assign phys_cur  = (sum_cur >= SumW'(DEPTH)) ? IdxW'(sum_cur - SumW'(DEPTH))
                                                : IdxW'(sum_cur);
   assign phys_prev = (sum_prev >= SumW'(DEPTH)) ? IdxW'(sum_prev - SumW'(DEPTH))
                                                 : IdxW'(sum_prev);
   assign rd_addr   = cmd.rd_prev ? phys_prev : head_ff;
   assign head_next = (head_ff == IdxW'(DEPTH - 1)) ? '0 : head_ff + IdxW'(1);
   assign wr_en     = cmd.wr_shift | cmd.wr_key;
   assign wr_data   = cmd.wr_key ? key_ff : rdata_ff;

   always_ff @(posedge clock) begin
      rdata_ff <= mem[rd_addr];
      if (wr_en) begin
         mem[phys_cur] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff  <= req_key;
         idx_ff  <= IdxW'(count_ff);
         take_ff <= '0;
      end else begin
         if (cmd.idx_dec) begin
            idx_ff <= idx_prev;
         end
         if (cmd.deq_take) begin
            take_ff <= rdata_ff;
         end
      end
      if (cmd.out_load) begin
         value_ff  <= take_ff;
         status_ff <= cmd.out_code;
         occ_ff    <= spq_pkg::OccWidth'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (cmd.deq_take) begin
            head_ff  <= head_next;
            count_ff <= count_ff - CntW'(1);
         end else if (cmd.cnt_inc) begin
            count_ff <= count_ff + CntW'(1);
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   assign sts.full     = (count_ff == CntW'(DEPTH));
   assign sts.empty    = (count_ff == '0);
   assign sts.greater  = (rdata_ff > key_ff);
   assign sts.idx_one  = (idx_ff == IdxW'(1));
   assign sts.out_free = !valid_ff || !rsp_stall;

   assign rsp_valid     = valid_ff;
   assign rsp_value     = value_ff;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = occ_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH))
      else $error("entry count above depth");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (status_ff == spq_pkg::ST_FULL) |-> occ_ff == spq_pkg::OccWidth'(DEPTH))
      else $error("full drop reported with wrong occupancy");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (status_ff == spq_pkg::ST_EMPTY) |-> (occ_ff == '0) && (value_ff == '0))
      else $error("empty dequeue reported wrong fields");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |=> count_ff == $past(count_ff) + CntW'(1))
      else $error("insert did not grow the count");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !valid_ff || !rsp_stall)
      else $error("result overwritten while stalled");

endmodule

`default_nettype wire

[tb/sorted_priority_queue_checker.sv]
// Result checker for the sorted priority queue: tracks the key store and compares results.
`timescale 1ns / 1ps

module sorted_priority_queue_checker #(
   parameter int DEPTH = spq_pkg::DefaultDepth
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_stall,
   input  wire logic                                req_action,
   input  wire logic signed [spq_pkg::KeyWidth-1:0] req_key,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   input  wire logic signed [spq_pkg::KeyWidth-1:0] rsp_value,
   input  wire logic [1:0]                          rsp_status,
   input  wire logic [spq_pkg::OccWidth-1:0]        rsp_occupancy,
   output int                                       fail_count,
   output int                                       outstanding
);

   typedef struct packed {
      logic signed [spq_pkg::KeyWidth-1:0] value;
      spq_pkg::status_type                 status;
      logic [spq_pkg::OccWidth-1:0]        occupancy;
   } queue_result_type;

   // Keys in ascending order; equal keys stay in arrival order.
   logic signed [spq_pkg::KeyWidth-1:0] ordered_keys[$];
   queue_result_type                    awaited_results[$];

   always @(posedge clock) begin : watch
      queue_result_type want;
      int               slot;
      if (reset) begin
         ordered_keys.delete();
         awaited_results.delete();
      end else begin
         if (req_valid && !req_stall) begin
            want.value  = '0;
            want.status = spq_pkg::ST_DONE;
            if (req_action == spq_pkg::ACT_ENQUEUE) begin
               if (ordered_keys.size() >= DEPTH) begin
                  want.status = spq_pkg::ST_FULL;
               end else begin
                  slot = 0;
                  while (slot < ordered_keys.size() && ordered_keys[slot] <= req_key)
                     slot++;
                  ordered_keys.insert(slot, req_key);
               end
            end else if (ordered_keys.size() == 0) begin
               want.status = spq_pkg::ST_EMPTY;
            end else begin
               want.value = ordered_keys.pop_front();
            end
            want.occupancy = spq_pkg::OccWidth'(ordered_keys.size());
            awaited_results.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: result expected none actual value %0d status %0d occupancy %0d",
                        $time, rsp_value, rsp_status, rsp_occupancy);
               fail_count++;
            end else begin
               want = awaited_results.pop_front();
               if (want.value !== rsp_value) begin
                  $display("%0t: value expected %0d actual %0d",
                           $time, want.value, rsp_value);
                  fail_count++;
               end
               if (want.status !== rsp_status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  fail_count++;
               end
               if (want.occupancy !== rsp_occupancy) begin
                  $display("%0t: occupancy expected %0d actual %0d",
                           $time, want.occupancy, rsp_occupancy);
                  fail_count++;
               end
            end
         end
      end
      outstanding = awaited_results.size();
   end

endmodule

[tb/sorted_priority_queue_top_test.sv]
// Testbench top for the sorted priority queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module sorted_priority_queue_top_test;

   localparam int Depth         = spq_pkg::DefaultDepth;
   localparam int ItemsPerPhase = 609;
   // Settle beyond the longest enqueue, one that examines every stored key.
   localparam int SettleCycles  = 2 + 2 * Depth + 8;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic                                req_action;
   logic signed [spq_pkg::KeyWidth-1:0] req_key;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic signed [spq_pkg::KeyWidth-1:0] rsp_value;
   logic [1:0]                          rsp_status;
   logic [spq_pkg::OccWidth-1:0]        rsp_occupancy;

   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int fail_count;
   int outstanding;

   sorted_priority_queue_top #(
      .DEPTH(Depth)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_key      (req_key),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_value    (rsp_value),
      .rsp_status   (rsp_status),
      .rsp_occupancy(rsp_occupancy)
   );

   sorted_priority_queue_checker #(
      .DEPTH(Depth)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_key      (req_key),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_value    (rsp_value),
      .rsp_status   (rsp_status),
      .rsp_occupancy(rsp_occupancy),
      .fail_count   (fail_count),
      .outstanding  (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the result channel at random, independent of rsp_valid.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Present one request and hold it until the block takes the transfer.
   // Insert random idle cycles ahead of it; valid stays high back to back
   // when no gap is drawn.
   task automatic send_item(input spq_pkg::action_type act,
                            input logic signed [spq_pkg::KeyWidth-1:0] k);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_key    <= k;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   initial begin : stimulus
      spq_pkg::action_type                 act;
      logic signed [spq_pkg::KeyWidth-1:0] k;
      int                                  left;
      int                                  run_len;
      int                                  enq_pct;

      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_action <= spq_pkg::ACT_ENQUEUE;
      req_key    <= '0;
      rsp_stall  <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part: dequeue on empty, extreme and equal keys, fill to full,
      // overflow, then take a few from the head.
      send_item(spq_pkg::ACT_DEQUEUE, $urandom);
      send_item(spq_pkg::ACT_ENQUEUE, 32'sh7FFF_FFFF);
      send_item(spq_pkg::ACT_ENQUEUE, 32'sh8000_0000);
      send_item(spq_pkg::ACT_ENQUEUE, 0);
      send_item(spq_pkg::ACT_ENQUEUE, -1);
      send_item(spq_pkg::ACT_ENQUEUE, 0);
      send_item(spq_pkg::ACT_ENQUEUE, 7);
      send_item(spq_pkg::ACT_ENQUEUE, 7);
      send_item(spq_pkg::ACT_ENQUEUE, -1);
      send_item(spq_pkg::ACT_DEQUEUE, 32'sh7FFF_FFFF);
      // Seven keys stored; top up to Depth with repeating small keys.
      for (int j = 0; j < Depth - 7; j++)
         send_item(spq_pkg::ACT_ENQUEUE, ((j * 7) % 5) - 2);
      send_item(spq_pkg::ACT_ENQUEUE, -5);
      repeat (4) send_item(spq_pkg::ACT_DEQUEUE, $urandom);

      // Random part in three idling phases. Runs are drawn at random among
      // filling, draining and balanced mixes so both the full and the
      // empty queue come up often.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct  = 12;
               rsp_stall_pct = 63;
            end
            1: begin
               req_idle_pct  = 63;
               rsp_stall_pct = 12;
            end
            default: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
         endcase
         left = ItemsPerPhase;
         while (left > 0) begin
            run_len = $urandom_range(48, 8);
            case ($urandom_range(2))
               0:       enq_pct = 85;
               1:       enq_pct = 15;
               default: enq_pct = 50;
            endcase
            for (int j = 0; j < run_len && left > 0; j++) begin
               act = ($urandom_range(99) < enq_pct) ? spq_pkg::ACT_ENQUEUE
                                                     : spq_pkg::ACT_DEQUEUE;
               case ($urandom_range(9))
                  0: begin
                     case ($urandom_range(6))
                        0:       k = 32'sh7FFF_FFFF;
                        1:       k = 32'sh8000_0000;
                        2:       k = 32'sh7FFF_FFFE;
                        3:       k = 32'sh8000_0001;
                        4:       k = -1;
                        5:       k = 1;
                        default: k = 0;
                     endcase
                  end
                  // Narrow range: many equal keys.
                  1, 2, 3: k = int'($urandom_range(8)) - 4;
                  default: k = $urandom;
               endcase
               send_item(act, k);
               left--;
            end
         end
      end

      // Drop valid, drain every awaited result, then let the block settle.
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0)
         @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Abort a hung run well past the slowest legal finish.
   initial begin
      #8_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
